[hdl/cma_pkg.sv]
package cma_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int SAMPLE_W        = 16;
	localparam int BYTE_W          = 8;
	localparam int SUM_W           = 16;
	localparam int APB_ADDR_W      = 4;
	localparam int APB_DATA_W      = 32;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_CLAMP_LOW     = 2'd0;
	localparam logic [1:0] REG_CLAMP_HIGH    = 2'd1;
	localparam logic [1:0] REG_BUFFER_LENGTH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_START,
		ST_DIV,
		ST_DONE
	} cma_state_t;

	// window store commands from the sequencer
	typedef struct packed {
		logic rd;
		logic upd;
		logic clr;
	} win_cmd_t;

endpackage

[hdl/clamped_moving_average.sv]
// Clamped moving average: one result per sample; from input transfer to result it steps through
// read, update, divider start, 16 restoring divide steps and output load.
// A new sample is taken only once the previous one has reached the output register.
// The output register lets a new sample in while a result waits on m_tready.
// Reset (arst_n low, asynchronous) clears window, sum, index, last sample and
// restores clamp_low=0, clamp_high=255, buffer_length=255.
module clamped_moving_average import cma_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB config port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// sample stream in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] raw_sample
	// result stream out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata    // [7:0] window_mean, [23:8] last_raw
);

	localparam int LEN_W = $clog2(STORE_DEPTH + 1);

	// ---------------- configuration registers ----------------
	logic [BYTE_W-1:0] clamp_low_q;
	logic [BYTE_W-1:0] clamp_high_q;
	logic [BYTE_W-1:0] buffer_length_q;
	logic              cfg_wr;
	logic              len_clr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign len_clr = cfg_wr && (paddr[3:2] == REG_BUFFER_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q     <= '0;
			clamp_high_q    <= '1;
			buffer_length_q <= '1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CLAMP_LOW:     clamp_low_q     <= pwdata[BYTE_W-1:0];
				REG_CLAMP_HIGH:    clamp_high_q    <= pwdata[BYTE_W-1:0];
				REG_BUFFER_LENGTH: buffer_length_q <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CLAMP_LOW:     prdata = APB_DATA_W'(clamp_low_q);
			REG_CLAMP_HIGH:    prdata = APB_DATA_W'(clamp_high_q);
			REG_BUFFER_LENGTH: prdata = APB_DATA_W'(buffer_length_q);
			default:           prdata = '0;
		endcase
	end

	// effective window length: zero acts as one, saturate at the store depth
	logic [LEN_W-1:0] eff_len;

	always_comb begin
		if (buffer_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if ({1'b0, buffer_length_q} > 9'(STORE_DEPTH)) begin
			eff_len = LEN_W'(STORE_DEPTH);
		end else begin
			eff_len = LEN_W'(buffer_length_q);
		end
	end

	// ---------------- input capture and clamp ----------------
	logic [SAMPLE_W-1:0] raw_q;
	logic [BYTE_W-1:0]   clamped_q;
	logic [BYTE_W-1:0]   clamped;
	logic                in_xfer;

	// low bound checked first; high bound only for samples not below it
	always_comb begin
		if (s_tdata < SAMPLE_W'(clamp_low_q)) begin
			clamped = clamp_low_q;
		end else if (s_tdata > SAMPLE_W'(clamp_high_q)) begin
			clamped = clamp_high_q;
		end else begin
			clamped = s_tdata[BYTE_W-1:0];
		end
	end

	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			raw_q     <= s_tdata;
			clamped_q <= clamped;
		end
	end

	// ---------------- sequencer ----------------
	cma_state_t state_q, state_nxt;
	win_cmd_t   win_cmd;
	logic       div_start;
	logic       div_done;
	logic       out_load;
	logic       m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_xfer) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_START;
			ST_START:  state_nxt = ST_DIV;
			ST_DIV:    if (div_done) state_nxt = ST_DONE;
			ST_DONE:   if (!m_tvalid_q || m_tready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		win_cmd     = '0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		win_cmd.clr = len_clr;
		unique case (state_q)
			ST_IDLE:   s_tready    = 1'b1;
			ST_READ:   win_cmd.rd  = 1'b1;
			ST_UPDATE: win_cmd.upd = 1'b1;
			ST_START:  div_start   = 1'b1;
			ST_DIV:    ;
			ST_DONE:   out_load    = !m_tvalid_q || m_tready;
			default:   ;
		endcase
	end

	// ---------------- window store and running sum ----------------
	logic [SUM_W-1:0] window_sum;

	cma_window #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.sample (clamped_q),
		.len    (eff_len),
		.sum    (window_sum)
	);

	// ---------------- divider: sum / length ----------------
	logic [SUM_W-1:0] quotient;

	cma_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (window_sum),
		.divisor  (eff_len),
		.done     (div_done),
		.quotient (quotient)
	);

	// ---------------- output register ----------------
	logic [BYTE_W-1:0]   mean_q;
	logic [SAMPLE_W-1:0] last_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q     <= '0;
			last_raw_q <= '0;
		end else if (out_load) begin
			mean_q     <= quotient[BYTE_W-1:0];
			last_raw_q <= raw_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {last_raw_q, mean_q};

endmodule

[hdl/cma_div.sv]
module cma_div import cma_pkg::*; #(
	parameter int DIVIDEND_W = SUM_W,
	parameter int DIVISOR_W  = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;

	// one restoring step per cycle, MSB first
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor};

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DIVISOR_W]) begin
				rem_q <= diff[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

endmodule

[hdl/cma_window.sv]
module cma_window import cma_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  win_cmd_t                            cmd,
	input  logic [BYTE_W-1:0]                   sample,
	input  logic [$clog2(STORE_DEPTH+1)-1:0]    len,
	output logic [SUM_W-1:0]                    sum
);

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int LEN_W = $clog2(STORE_DEPTH + 1);

	logic [BYTE_W-1:0] mem [STORE_DEPTH];

	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic              old_valid_q;
	logic [BYTE_W-1:0] rd_data_q;

	logic [IDX_W-1:0]  rd_idx;
	logic [BYTE_W-1:0] old_byte;
	logic [LEN_W-1:0]  next_idx;

	// entries at or beyond the fill count have not been written since the clear
	assign rd_idx   = ({1'b0, idx_q} >= (IDX_W+1)'(len)) ? '0 : idx_q;
	assign old_byte = old_valid_q ? rd_data_q : '0;
	assign next_idx = LEN_W'(cur_idx_q) + 1'b1;
	assign sum      = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			cur_idx_q   <= '0;
			old_valid_q <= 1'b0;
		end else if (cmd.clr) begin
			idx_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.rd) begin
			cur_idx_q   <= rd_idx;
			old_valid_q <= (LEN_W'(rd_idx) < fill_q);
		end else if (cmd.upd) begin
			sum_q <= sum_q - SUM_W'(old_byte) + SUM_W'(sample);
			idx_q <= (next_idx >= len) ? '0 : next_idx[IDX_W-1:0];
			if (fill_q == LEN_W'(cur_idx_q)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[rd_idx];
		end
		if (cmd.upd) begin
			mem[cur_idx_q] <= sample;
		end
	end

endmodule
